>>> rtl/ts_audio_payload_extractor_defines.svh
// Assertion macros used by the top level of the transport-stream payload extractor RTL.
`ifndef TS_AUDIO_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define TS_AUDIO_PAYLOAD_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TSAPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TSAPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tsape_pkg.sv
// Types, constants and register codes of the transport-stream payload extractor.
`default_nettype none
package tsape_pkg;

    localparam int PACKET_BYTES_DEF = 188;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_PID     = 3'd0,
        CFG_START_SKIP     = 3'd1,
        CFG_HEADER_SKIP    = 3'd2,
        CFG_EXPECTED_BYTES = 3'd3,
        CFG_SWAP_ENABLE    = 3'd4
    } cfg_index_t;

    localparam logic [12:0] TARGET_PID_RST     = 13'h1100;
    localparam logic [7:0]  START_SKIP_RST     = 8'd20;
    localparam logic [7:0]  HEADER_SKIP_RST    = 8'd12;
    localparam logic [15:0] EXPECTED_BYTES_RST = 16'd1920;
    localparam logic        SWAP_ENABLE_RST    = 1'b1;

    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADAPT      = 2'd1;
    localparam logic [1:0] STATUS_TOTAL_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_PARTIAL        = 2'd3;

    localparam logic [1:0] AFC_PAYLOAD_ONLY  = 2'd1;
    localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'd3;

    localparam logic [15:0] BYTE_TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       datagram_start;
        logic       slice_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       buffer_end;
        logic [1:0] status;
    } out_beat_t;

    typedef struct packed {
        logic [12:0] target_pid;
        logic [7:0]  start_skip;
        logic [7:0]  header_skip;
        logic [15:0] expected_bytes;
        logic        swap_enable;
    } cfg_t;

    // one queue entry: the one or two results caused by one input beat
    typedef struct packed {
        logic       two_res;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       buffer_end;
        logic [1:0] status;
    } qent_t;

endpackage
`default_nettype wire

>>> rtl/tsape_front.sv
// Front end: datagram/packet parser, payload selection, pairing and slice status.
`default_nettype none
module tsape_front
    import tsape_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_beat_t beat,
    input  wire cfg_t     cfg,
    output logic          push,
    output qent_t         entry
);

    localparam int IdxW = $clog2(PACKET_BYTES);
    localparam logic [IdxW-1:0] IdxLast = IdxW'(PACKET_BYTES - 1);

    logic [7:0]      header_left_reg,   header_left_next;
    logic [IdxW-1:0] packet_index_reg,  packet_index_next;
    logic [12:0]     packet_pid_reg,    packet_pid_next;
    logic            unit_start_reg,    unit_start_next;
    logic [1:0]      adapt_control_reg, adapt_control_next;
    logic [7:0]      skip_left_reg,     skip_left_next;
    logic [7:0]      pending_byte_reg,  pending_byte_next;
    logic            pending_valid_reg, pending_valid_next;
    logic [15:0]     byte_total_reg,    byte_total_next;
    logic [1:0]      error_code_reg,    error_code_next;

    logic [1:0] n_res;
    logic [7:0] res0;
    logic [7:0] res1;
    logic [1:0] st;
    logic       match;
    logic [7:0] b;

    always_comb
    begin
        header_left_next   = header_left_reg;
        packet_index_next  = packet_index_reg;
        packet_pid_next    = packet_pid_reg;
        unit_start_next    = unit_start_reg;
        adapt_control_next = adapt_control_reg;
        skip_left_next     = skip_left_reg;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        byte_total_next    = byte_total_reg;
        error_code_next    = error_code_reg;
        n_res = 2'd0;
        res0  = 8'd0;
        res1  = 8'd0;
        st    = STATUS_OK;
        b     = beat.data_byte;
        match = (packet_pid_reg == cfg.target_pid);

        if (fire)
        begin
            if (beat.datagram_start)
            begin
                if ((packet_index_next != '0 || header_left_next != 8'd0)
                    && error_code_next == STATUS_OK)
                    error_code_next = STATUS_PARTIAL;
                packet_index_next = '0;
                header_left_next  = cfg.header_skip;
            end

            if (header_left_next != 8'd0)
            begin
                header_left_next = header_left_next - 8'd1;
            end
            else
            begin
                if (packet_index_next == IdxW'(1))
                begin
                    unit_start_next = b[6];
                    packet_pid_next = {b[4:0], 8'h00};
                end
                else if (packet_index_next == IdxW'(2))
                begin
                    packet_pid_next = packet_pid_next | {5'd0, b};
                end
                else if (packet_index_next == IdxW'(3))
                begin
                    adapt_control_next = b[5:4];
                    skip_left_next     = 8'd0;
                    if (match)
                    begin
                        if (unit_start_next)
                        begin
                            skip_left_next = cfg.start_skip;
                            if (b[5:4] != AFC_PAYLOAD_ONLY && error_code_next == STATUS_OK)
                                error_code_next = STATUS_BAD_ADAPT;
                        end
                        else if (b[5:4] != AFC_PAYLOAD_ONLY && b[5:4] != AFC_ADAPT_PAYLOAD
                                 && error_code_next == STATUS_OK)
                        begin
                            error_code_next = STATUS_BAD_ADAPT;
                        end
                    end
                end
                else if (packet_index_next >= IdxW'(4))
                begin
                    if (match && (unit_start_next || adapt_control_next == AFC_PAYLOAD_ONLY
                                  || adapt_control_next == AFC_ADAPT_PAYLOAD))
                    begin
                        if (!unit_start_next && adapt_control_next == AFC_ADAPT_PAYLOAD
                            && packet_index_next == IdxW'(4))
                        begin
                            skip_left_next = b;
                        end
                        else if (skip_left_next != 8'd0)
                        begin
                            skip_left_next = skip_left_next - 8'd1;
                        end
                        else
                        begin
                            if (byte_total_next != BYTE_TOTAL_MAX)
                                byte_total_next = byte_total_next + 16'd1;
                            if (cfg.swap_enable)
                            begin
                                if (pending_valid_next)
                                begin
                                    res0 = b;
                                    res1 = pending_byte_next;
                                    n_res = 2'd2;
                                    pending_valid_next = 1'b0;
                                end
                                else
                                begin
                                    pending_byte_next  = b;
                                    pending_valid_next = 1'b1;
                                end
                            end
                            else
                            begin
                                if (pending_valid_next)
                                begin
                                    res0 = pending_byte_next;
                                    res1 = b;
                                    n_res = 2'd2;
                                    pending_valid_next = 1'b0;
                                end
                                else
                                begin
                                    res0 = b;
                                    n_res = 2'd1;
                                end
                            end
                        end
                    end
                end
                packet_index_next = (packet_index_next == IdxLast) ? '0
                                                                   : packet_index_next + IdxW'(1);
            end

            if (beat.slice_end)
            begin
                // a waiting byte only exists here when nothing was emitted yet
                if (pending_valid_next)
                begin
                    res0 = pending_byte_next;
                    n_res = 2'd1;
                end
                if ((packet_index_next != '0 || header_left_next != 8'd0)
                    && error_code_next == STATUS_OK)
                    error_code_next = STATUS_PARTIAL;
                if (error_code_next != STATUS_OK)
                    st = error_code_next;
                else if (byte_total_next != cfg.expected_bytes)
                    st = STATUS_TOTAL_MISMATCH;
                else
                    st = STATUS_OK;
                if (n_res == 2'd0)
                begin
                    res0 = 8'd0;
                    n_res = 2'd1;
                end
                header_left_next   = 8'd0;
                packet_index_next  = '0;
                skip_left_next     = 8'd0;
                pending_byte_next  = 8'd0;
                pending_valid_next = 1'b0;
                byte_total_next    = 16'd0;
                error_code_next    = STATUS_OK;
            end
        end

        push             = fire && (n_res != 2'd0);
        entry.two_res    = (n_res == 2'd2);
        entry.byte0      = res0;
        entry.byte1      = res1;
        entry.buffer_end = beat.slice_end;
        entry.status     = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg   <= 8'd0;
            packet_index_reg  <= '0;
            packet_pid_reg    <= 13'd0;
            unit_start_reg    <= 1'b0;
            adapt_control_reg <= 2'd0;
            skip_left_reg     <= 8'd0;
            pending_byte_reg  <= 8'd0;
            pending_valid_reg <= 1'b0;
            byte_total_reg    <= 16'd0;
            error_code_reg    <= STATUS_OK;
        end
        else
        begin
            header_left_reg   <= header_left_next;
            packet_index_reg  <= packet_index_next;
            packet_pid_reg    <= packet_pid_next;
            unit_start_reg    <= unit_start_next;
            adapt_control_reg <= adapt_control_next;
            skip_left_reg     <= skip_left_next;
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            byte_total_reg    <= byte_total_next;
            error_code_reg    <= error_code_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tsape_queue.sv
// Short result queue between the parser front end and the output back end.
`default_nettype none
module tsape_queue
    import tsape_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_data,
    input  wire logic  pop,
    output logic       full,
    output logic       head_valid,
    output qent_t      head
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

    qent_t           mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    assign full       = (count_reg == CntW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tsape_back.sv
// Back end: unpacks queue entries into single result beats through an output register.
`default_nettype none
module tsape_back
    import tsape_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  wire qent_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_beat_t  out_data
);

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg,  out_data_next;
    logic      half_reg,      half_next;
    logic      load;
    logic      last;

    always_comb
    begin
        load           = head_valid && (!out_valid_reg || !out_stall);
        last           = half_reg || !head.two_res;
        pop            = load && last;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = half_reg ? head.byte1 : head.byte0;
            out_data_next.buffer_end = last && head.buffer_end;
            out_data_next.status   = (last && head.buffer_end) ? head.status : STATUS_OK;
            half_next              = !last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ts_audio_payload_extractor.sv
// Path: a beat accepted at the input is written into the result queue, then loaded into the output
// register that drives out_data; a second result of the same beat follows the first.
// Throughput: one input beat per cycle while the queue is not full; the output register sends one
// result per cycle while out_stall is low, so a beat that yields two results holds the output for both.
// in_stall rises only while the result queue (QUEUE_DEPTH entries) is full.
// Reset: rst_n clears parser state, queue and output; registers return to defaults.
`default_nettype none
`include "ts_audio_payload_extractor_defines.svh"
module ts_audio_payload_extractor
    import tsape_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_beat_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_beat_t                   out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  fire;
    logic  push;
    qent_t entry;
    logic  q_full;
    logic  q_valid;
    qent_t q_head;
    logic  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_pid     <= TARGET_PID_RST;
            cfg_reg.start_skip     <= START_SKIP_RST;
            cfg_reg.header_skip    <= HEADER_SKIP_RST;
            cfg_reg.expected_bytes <= EXPECTED_BYTES_RST;
            cfg_reg.swap_enable    <= SWAP_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_PID:     cfg_reg.target_pid     <= cfg_data[12:0];
                CFG_START_SKIP:     cfg_reg.start_skip     <= cfg_data[7:0];
                CFG_HEADER_SKIP:    cfg_reg.header_skip    <= cfg_data[7:0];
                CFG_EXPECTED_BYTES: cfg_reg.expected_bytes <= cfg_data;
                CFG_SWAP_ENABLE:    cfg_reg.swap_enable    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign fire     = in_valid && !q_full;

    tsape_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .beat  (in_data),
        .cfg   (cfg_reg),
        .push  (push),
        .entry (entry)
    );

    tsape_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    tsape_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    `TSAPE_ASSERT_NOW(a_status_on_end, clk, rst_n, out_valid && out_data.status != STATUS_OK, out_data.buffer_end, "status without buffer_end")
    `TSAPE_ASSERT_NEXT(a_slice_end_queued, clk, rst_n, in_valid && !in_stall && in_data.slice_end, q_valid, "slice end beat produced no queue entry")
    `TSAPE_ASSERT_NEXT(a_no_spurious_out, clk, rst_n, !out_valid && !q_valid, !out_valid, "result beat from empty queue")

endmodule
`default_nettype wire

>>> sim/ts_audio_payload_extractor_test.sv
// Self-checking testbench of the transport-stream payload extractor.
module ts_audio_payload_extractor_test
    import tsape_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_BYTES      = PACKET_BYTES_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BEATS    = 15;
    localparam int MAX_PRINTS     = 40;

    // adaptation control values that are not allowed without unit start
    localparam logic [1:0] AFC_RESERVED   = 2'd0;
    localparam logic [1:0] AFC_ADAPT_ONLY = 2'd2;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    class payload_checker;
        cfg_t        regs;
        logic [7:0]  header_left;
        logic [7:0]  packet_index;
        logic [12:0] packet_pid;
        logic        unit_start;
        logic [1:0]  adapt_control;
        logic [7:0]  skip_left;
        logic [7:0]  pending_byte;
        logic        pending_valid;
        logic [15:0] byte_total;
        logic [1:0]  error_code;
        out_beat_t   step_q[$];
        out_beat_t   payload_due[$];
        int          fails;

        function new();
            regs.target_pid     = TARGET_PID_RST;
            regs.start_skip     = START_SKIP_RST;
            regs.header_skip    = HEADER_SKIP_RST;
            regs.expected_bytes = EXPECTED_BYTES_RST;
            regs.swap_enable    = SWAP_ENABLE_RST;
            header_left   = '0;
            packet_index  = '0;
            packet_pid    = '0;
            unit_start    = 1'b0;
            adapt_control = '0;
            skip_left     = '0;
            pending_byte  = '0;
            pending_valid = 1'b0;
            byte_total    = '0;
            error_code    = '0;
            fails         = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TARGET_PID:     regs.target_pid     = v[12:0];
                CFG_START_SKIP:     regs.start_skip     = v[7:0];
                CFG_HEADER_SKIP:    regs.header_skip    = v[7:0];
                CFG_EXPECTED_BYTES: regs.expected_bytes = v;
                CFG_SWAP_ENABLE:    regs.swap_enable    = v[0];
                default: ;
            endcase
        endfunction

        function int waiting();
            return payload_due.size();
        endfunction

        function void flag(logic [1:0] code);
            if (error_code == STATUS_OK)
                error_code = code;
        endfunction

        function void emit(logic [7:0] d);
            out_beat_t r;
            r.out_byte   = d;
            r.buffer_end = 1'b0;
            r.status     = STATUS_OK;
            step_q.push_back(r);
        endfunction

        function void take(logic [7:0] d);
            if (byte_total != BYTE_TOTAL_MAX)
                byte_total = byte_total + 16'd1;
            if (regs.swap_enable)
            begin
                if (pending_valid)
                begin
                    emit(d);
                    emit(pending_byte);
                    pending_valid = 1'b0;
                end
                else
                begin
                    pending_byte  = d;
                    pending_valid = 1'b1;
                end
            end
            else
            begin
                if (pending_valid)
                begin
                    emit(pending_byte);
                    pending_valid = 1'b0;
                end
                emit(d);
            end
        endfunction

        function void parse_byte(logic [7:0] d);
            logic [7:0] idx;
            logic       hit;
            idx = packet_index;
            hit = (packet_pid == regs.target_pid);
            if (idx == 8'd1)
            begin
                unit_start = d[6];
                packet_pid = {d[4:0], 8'h00};
            end
            else if (idx == 8'd2)
            begin
                packet_pid[7:0] = d;
            end
            else if (idx == 8'd3)
            begin
                adapt_control = d[5:4];
                skip_left = '0;
                if (hit)
                begin
                    if (unit_start)
                    begin
                        skip_left = regs.start_skip;
                        if (adapt_control != AFC_PAYLOAD_ONLY)
                            flag(STATUS_BAD_ADAPT);
                    end
                    else if (adapt_control != AFC_PAYLOAD_ONLY &&
                             adapt_control != AFC_ADAPT_PAYLOAD)
                    begin
                        flag(STATUS_BAD_ADAPT);
                    end
                end
            end
            else if (idx >= 8'd4)
            begin
                if (hit && (unit_start || adapt_control == AFC_PAYLOAD_ONLY ||
                            adapt_control == AFC_ADAPT_PAYLOAD))
                begin
                    if (!unit_start && adapt_control == AFC_ADAPT_PAYLOAD && idx == 8'd4)
                        skip_left = d;
                    else if (skip_left > 0)
                        skip_left = skip_left - 8'd1;
                    else
                        take(d);
                end
            end
            if (int'(idx) + 1 >= PKT_BYTES)
                packet_index = '0;
            else
                packet_index = idx + 8'd1;
        endfunction

        function void note_beat(in_beat_t b);
            logic [1:0] st;
            out_beat_t  last_r;
            step_q = {};
            if (b.datagram_start)
            begin
                if (packet_index != 0 || header_left != 0)
                    flag(STATUS_PARTIAL);
                packet_index = '0;
                header_left  = regs.header_skip;
            end
            if (header_left > 0)
                header_left = header_left - 8'd1;
            else
                parse_byte(b.data_byte);
            if (b.slice_end)
            begin
                if (pending_valid)
                begin
                    emit(pending_byte);
                    pending_valid = 1'b0;
                end
                if (packet_index != 0 || header_left != 0)
                    flag(STATUS_PARTIAL);
                if (error_code != STATUS_OK)
                    st = error_code;
                else if (byte_total != regs.expected_bytes)
                    st = STATUS_TOTAL_MISMATCH;
                else
                    st = STATUS_OK;
                if (step_q.size() == 0)
                    emit(8'h00);
                last_r = step_q.pop_back();
                last_r.buffer_end = 1'b1;
                last_r.status     = st;
                step_q.push_back(last_r);
                header_left   = '0;
                packet_index  = '0;
                skip_left     = '0;
                pending_byte  = '0;
                pending_valid = 1'b0;
                byte_total    = '0;
                error_code    = '0;
            end
            foreach (step_q[i])
                payload_due.push_back(step_q[i]);
        endfunction

        task report(string msg);
            fails++;
            if (fails <= MAX_PRINTS)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(out_beat_t r);
            out_beat_t e;
            if (payload_due.size() == 0)
            begin
                report($sformatf("unexpected result %h", r));
            end
            else
            begin
                e = payload_due.pop_front();
                if (r.out_byte !== e.out_byte)
                    report($sformatf("out_byte %h, want %h", r.out_byte, e.out_byte));
                if (r.buffer_end !== e.buffer_end)
                    report($sformatf("buffer_end %b, want %b", r.buffer_end, e.buffer_end));
                if (r.status !== e.status)
                    report($sformatf("status %0d, want %0d", r.status, e.status));
            end
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_beat_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_beat_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    payload_checker sb;
    in_beat_t       slice_q[$];
    logic           dg_flag;
    int             idle_pct;
    int             stall_pct;
    int             quiet_cycles;
    int             phase_beats;
    cfg_t           reg_sets[4];

    ts_audio_payload_extractor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_beat(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic set_mode(idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                idle_pct  = 81;
                stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                idle_pct  = 0;
                stall_pct = 81;
            end
            default:
            begin
                idle_pct  = 9;
                stall_pct = 9;
            end
        endcase
    endtask

    task automatic send_beat(in_beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_head(int n);
        for (int i = 0; i < n; i++)
            send_beat(slice_q.pop_front());
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(cfg_t c);
        settle();
        write_reg(CFG_TARGET_PID, 16'(c.target_pid));
        write_reg(CFG_START_SKIP, 16'(c.start_skip));
        write_reg(CFG_HEADER_SKIP, 16'(c.header_skip));
        write_reg(CFG_EXPECTED_BYTES, c.expected_bytes);
        write_reg(CFG_SWAP_ENABLE, 16'(c.swap_enable));
    endtask

    function automatic void put(logic [7:0] d);
        in_beat_t b;
        b.data_byte      = d;
        b.datagram_start = dg_flag;
        b.slice_end      = 1'b0;
        slice_q.push_back(b);
        dg_flag = 1'b0;
    endfunction

    function automatic void new_datagram();
        dg_flag = 1'b1;
        repeat (sb.regs.header_skip) put(8'($urandom));
    endfunction

    // first keep bytes of a packet; fill < 0: random payload, else every byte after b4 is fill
    function automatic void add_packet(logic [12:0] pid, logic us, logic [1:0] afc,
                                       logic [7:0] b4, int fill, int keep);
        for (int i = 0; i < keep; i++)
        begin
            case (i)
                0:       put(($urandom_range(7) == 0) ? 8'($urandom) : 8'h47);
                1:       put({1'($urandom), us, 1'($urandom), pid[12:8]});
                2:       put(pid[7:0]);
                3:       put({2'($urandom), afc, 4'($urandom)});
                4:       put(b4);
                default: put((fill < 0) ? 8'($urandom) : 8'(fill));
            endcase
        end
    endfunction

    function automatic void close_slice();
        in_beat_t b;
        b = slice_q.pop_back();
        b.slice_end = 1'b1;
        slice_q.push_back(b);
    endfunction

    function automatic void random_packet(int keep);
        logic [12:0] pid;
        logic [1:0]  afc;
        logic [7:0]  b4;
        int          x;
        pid = ($urandom_range(3) == 0) ? 13'($urandom) : sb.regs.target_pid;
        x = $urandom_range(9);
        if (x < 4)
            afc = AFC_PAYLOAD_ONLY;
        else if (x < 8)
            afc = AFC_ADAPT_PAYLOAD;
        else if (x == 8)
            afc = AFC_RESERVED;
        else
            afc = AFC_ADAPT_ONLY;
        case ($urandom_range(7))
            0:       b4 = 8'd0;
            1:       b4 = 8'd255;
            2:       b4 = 8'd183;
            3:       b4 = 8'd3;
            default: b4 = 8'($urandom_range(20));
        endcase
        add_packet(pid, ($urandom_range(3) == 0), afc, b4, -1, keep);
    endfunction

    function automatic void random_slice();
        in_beat_t b;
        int       r;
        int       n;
        r = $urandom_range(99);
        if (r < 15)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                b.data_byte      = 8'($urandom);
                b.datagram_start = ($urandom_range(5) == 0);
                b.slice_end      = ($urandom_range(19) == 0);
                slice_q.push_back(b);
            end
        end
        else
        begin
            n = $urandom_range(1, 2);
            for (int d = 0; d < n; d++)
            begin
                new_datagram();
                random_packet($urandom_range(1, 28));
            end
        end
        close_slice();
    endfunction

    initial
    begin
        sb = new();
        dg_flag = 1'b0;
        quiet_cycles = 0;
        set_mode(IDLE_NONE);
        reg_sets[0] = '{13'h0000, 8'd0,   8'd0, 16'd0,     1'b1};
        reg_sets[1] = '{13'h1FFF, 8'd184, 8'd4, 16'hFFFF,  1'b0};
        reg_sets[2] = '{13'h0ABC, 8'd7,   8'd3, 16'd6,     1'b0};
        reg_sets[3] = '{13'h1100, 8'd20,  8'd2, 16'd4,     1'b1};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // new datagram inside a header, then a packet with no payload for us
        new_datagram();
        repeat (5) void'(slice_q.pop_back());
        new_datagram();
        add_packet(13'h0123, 1'b0, AFC_PAYLOAD_ONLY, 8'h00, -1, 10);
        close_slice();
        send_head(slice_q.size());

        // one whole packet: adaptation field, odd payload tail, total matches
        settle();
        write_reg(CFG_HEADER_SKIP, 16'd1);
        write_reg(CFG_EXPECTED_BYTES, 16'd83);
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b0, AFC_ADAPT_PAYLOAD, 8'd100, -1, PKT_BYTES);
        close_slice();
        send_head(slice_q.size());

        // unit start with a bad control is still extracted after start_skip
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b1, AFC_RESERVED, 8'hFF, -1, 28);
        close_slice();
        send_head(slice_q.size());

        // bad control without unit start extracts nothing
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b0, AFC_ADAPT_ONLY, 8'h00, -1, 12);
        close_slice();
        send_head(slice_q.size());

        // adaptation lengths zero and short, cut packets between datagrams
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b0, AFC_ADAPT_PAYLOAD, 8'd0, -1, 12);
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b0, AFC_ADAPT_PAYLOAD, 8'd5, -1, 16);
        close_slice();
        send_head(slice_q.size());

        // start and end on the same beat
        slice_q.push_back('{8'h00, 1'b1, 1'b1});
        slice_q.push_back('{8'hFF, 1'b1, 1'b1});
        send_head(slice_q.size());

        // swap turned off while a byte waits for its partner
        new_datagram();
        add_packet(sb.regs.target_pid, 1'b0, AFC_ADAPT_PAYLOAD, 8'd0, -1, 12);
        close_slice();
        send_head(int'(sb.regs.header_skip) + 6);
        settle();
        write_reg(CFG_SWAP_ENABLE, 16'd0);
        send_head(slice_q.size());

        for (int p = 0; p < 4; p++)
        begin
            apply_setting(reg_sets[p]);
            set_mode(idle_mode_t'(p));
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                random_slice();
                phase_beats += slice_q.size();
                send_head(slice_q.size());
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/tsape_pkg.sv
rtl/tsape_front.sv
rtl/tsape_queue.sv
rtl/tsape_back.sv
rtl/ts_audio_payload_extractor.sv
sim/ts_audio_payload_extractor_test.sv
